### hw/rtl/mfe_pkg.sv
// mfe_pkg: shared types and constants for the metaball field evaluator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package mfe_pkg;

    localparam int unsigned SUM_W   = 50;  // squared distance, Q34.16
    localparam int unsigned NUM_W   = 48;  // divider dividend / quotient
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned PROD_W  = 82;  // 2*f * |D|
    localparam int unsigned TERM_W  = 41;  // clamped gradient term
    localparam int unsigned FACC_W  = 60;
    localparam int unsigned GACC_W  = 54;
    localparam int unsigned FDIV_STEPS = 48;
    localparam int unsigned GDIV_STEPS = 41;

    localparam logic [0:0] REG_RADIUS_SQ = 1'b0;
    localparam logic [0:0] REG_SPH_COUNT = 1'b1;
    localparam logic       REQ_WRITE     = 1'b0;
    localparam logic       REQ_QUERY     = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_READ,
        OP_DIST,
        OP_FDIV,
        OP_ZERO,
        OP_FACC,
        OP_MLO,
        OP_MHI,
        OP_GDIV,
        OP_GACC,
        OP_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic [1:0] axis;
    } t_dp_cmd;

    typedef struct packed {
        logic div_done;
        logic s_zero;
        logic gclamp;
    } t_dp_status;

endpackage
`default_nettype wire

### hw/rtl/mfe_div.sv
// mfe_div: restoring divider, one quotient bit per cycle.
// Depends on mfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfe_div
    import mfe_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_rem,   // must be below i_den
    input  wire logic [NUM_W-1:0]  i_num,   // remaining dividend bits, msb first
    input  wire logic [STEP_W-1:0] i_steps,
    input  wire logic [SUM_W-1:0]  i_den,
    output logic      [NUM_W-1:0]  o_quo,
    output logic                   o_done
);

    logic [SUM_W-1:0]  r_rem, r_den;
    logic [NUM_W-1:0]  r_num, r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done;
    logic [SUM_W:0]    w_trial;
    logic              w_ge;

    assign w_trial = {r_rem, r_num[NUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? SUM_W'(w_trial - {1'b0, r_den}) : SUM_W'(w_trial);
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_quo <= {r_quo[NUM_W-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule
`default_nettype wire

### hw/rtl/mfe_datapath.sv
// mfe_datapath: centre table, distance and product arithmetic, accumulators.
// Depends on mfe_pkg and mfe_div.
`timescale 1ns / 1ps
`default_nettype none
module mfe_datapath
    import mfe_pkg::*;
#(
    parameter int unsigned MAX_SPHERES = 256,
    parameter int unsigned AW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_req_type,
    input  wire logic [7:0]    i_sphere_index,
    input  wire logic [31:0]   i_coord_x,
    input  wire logic [31:0]   i_coord_y,
    input  wire logic [31:0]   i_coord_z,
    input  wire logic          i_coord_is_nan,
    input  wire logic [31:0]   i_radius_squared,
    input  wire t_dp_cmd       i_cmd,
    input  wire logic [AW-1:0] i_addr,
    output t_dp_status         o_status,
    output logic [31:0]        o_field_value,
    output logic [31:0]        o_grad_x,
    output logic [31:0]        o_grad_y,
    output logic [31:0]        o_grad_z,
    output logic               o_saturated,
    output logic               o_result_valid
);

    localparam logic [TERM_W-1:0] TERM_LIM = TERM_W'(1) << (TERM_W - 1);

    logic [95:0] r_mem [MAX_SPHERES];
    logic [95:0] r_cent;
    logic [31:0] r_p [3];
    logic [32:0] r_mag [3];
    logic [2:0]  r_neg;
    logic [SUM_W-1:0]  r_s;
    logic [NUM_W:0]    r_f2;
    logic [57:0]       r_plo;
    logic [PROD_W-1:0] r_prod;
    logic              r_gclamp;
    logic [FACC_W-1:0]        r_field;
    logic signed [GACC_W-1:0] r_grad [3];
    logic              r_fsat, r_sat, r_valid;
    logic [31:0] r_o_field, r_o_gx, r_o_gy, r_o_gz;
    logic        r_o_sat;

    logic              w_wr;
    logic [31:0]       w_c, w_pa;
    logic [32:0]       w_d, w_mag;
    logic [65:0]       w_sq;
    logic [32:0]       w_mag_sel;
    logic [56:0]       w_phi;
    logic [57:0]       w_plo;
    logic [PROD_W+8:0] w_lim;
    logic              w_clamp;
    logic              w_div_start;
    logic [SUM_W-1:0]  w_div_rem;
    logic [NUM_W-1:0]  w_div_num, w_quo;
    logic [STEP_W-1:0] w_div_steps;
    logic              w_div_done;
    logic [TERM_W-1:0] w_term;
    logic signed [GACC_W-1:0] w_term_s;
    logic signed [GACC_W-1:0] w_gsat [3];
    logic [31:0]       w_gout [3];
    logic [2:0]        w_gover;

    // table write; out-of-range index and NaN source are dropped
    assign w_wr = i_accept && (i_req_type == REQ_WRITE) && !i_coord_is_nan
                  && (32'(i_sphere_index) < MAX_SPHERES);

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[AW'(i_sphere_index)] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        if (i_cmd.op == OP_READ) begin
            r_cent <= r_mem[i_addr];
        end
    end

    always_comb begin
        case (i_cmd.axis)
            2'd0:    begin w_c = r_cent[31:0];  w_pa = r_p[0]; end
            2'd1:    begin w_c = r_cent[63:32]; w_pa = r_p[1]; end
            default: begin w_c = r_cent[95:64]; w_pa = r_p[2]; end
        endcase
    end

    assign w_d   = {w_c[31], w_c} - {w_pa[31], w_pa};
    assign w_mag = w_d[32] ? 33'(-w_d) : w_d;
    assign w_sq  = 66'(w_mag) * 66'(w_mag);

    assign w_mag_sel = r_mag[i_cmd.axis];
    assign w_plo = 58'(r_f2[24:0]) * 58'(w_mag_sel);
    assign w_phi = 57'(r_f2[NUM_W:25]) * 57'(w_mag_sel);

    // term > 2^40 exactly when prod >= (2^40 + 1) * S
    assign w_lim   = ((PROD_W+9)'(r_s) << (TERM_W - 1)) + (PROD_W+9)'(r_s);
    assign w_clamp = ((PROD_W+9)'(r_prod) >= w_lim);

    always_comb begin
        w_div_start = 1'b0;
        w_div_rem   = '0;
        w_div_num   = {i_radius_squared, 16'b0};
        w_div_steps = STEP_W'(FDIV_STEPS);
        case (i_cmd.op)
            OP_FDIV: w_div_start = 1'b1;
            OP_GDIV: begin
                w_div_start = !w_clamp;
                w_div_rem   = SUM_W'(r_prod[PROD_W-1:GDIV_STEPS]);
                w_div_num   = {r_prod[GDIV_STEPS-1:0], (NUM_W-GDIV_STEPS)'(0)};
                w_div_steps = STEP_W'(GDIV_STEPS);
            end
            default: ;
        endcase
    end

    mfe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_div_rem),
        .i_num   (w_div_num),
        .i_steps (w_div_steps),
        .i_den   (r_s),
        .o_quo   (w_quo),
        .o_done  (w_div_done)
    );

    assign w_term   = r_gclamp ? TERM_LIM : w_quo[TERM_W-1:0];
    assign w_term_s = r_neg[i_cmd.axis] ? -$signed(GACC_W'(w_term))
                                        : $signed(GACC_W'(w_term));

    for (genvar a = 0; a < 3; a++) begin : g_gsat
        assign w_gover[a] = (r_grad[a] > $signed(GACC_W'(32'h7FFF_FFFF)))
                            || (r_grad[a] < -$signed(GACC_W'(33'h0_8000_0000)));
        assign w_gsat[a] = r_grad[a];
        assign w_gout[a] = (r_grad[a] > $signed(GACC_W'(32'h7FFF_FFFF))) ? 32'h7FFF_FFFF :
                           (r_grad[a] < -$signed(GACC_W'(33'h0_8000_0000))) ? 32'h8000_0000 :
                           w_gsat[a][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_req_type == REQ_QUERY)) begin
            r_p[0] <= i_coord_x;
            r_p[1] <= i_coord_y;
            r_p[2] <= i_coord_z;
        end
        case (i_cmd.op)
            OP_DIST: begin
                r_mag[i_cmd.axis] <= w_mag;
                r_neg[i_cmd.axis] <= w_d[32];
                r_s <= ((i_cmd.axis == 2'd0) ? '0 : r_s) + SUM_W'(w_sq >> 16);
            end
            OP_FACC: r_f2 <= {w_quo, 1'b0};
            OP_MLO:  r_plo <= w_plo;
            OP_MHI:  r_prod <= PROD_W'(r_plo) + {w_phi, 25'b0};
            OP_GDIV: r_gclamp <= w_clamp;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_fsat  <= 1'b0;
            r_sat   <= 1'b0;
        end else begin
            r_valid <= (i_cmd.op == OP_DONE);
            if (i_accept && (i_req_type == REQ_QUERY)) begin
                r_fsat    <= 1'b0;
                r_sat     <= 1'b0;
                r_field   <= '0;
                r_grad[0] <= '0;
                r_grad[1] <= '0;
                r_grad[2] <= '0;
            end else begin
                case (i_cmd.op)
                    OP_ZERO: begin
                        r_fsat <= 1'b1;
                        r_sat  <= 1'b1;
                    end
                    OP_FACC: r_field <= r_field + FACC_W'(w_quo);
                    OP_GDIV: if (w_clamp) r_sat <= 1'b1;
                    OP_GACC: r_grad[i_cmd.axis] <= r_grad[i_cmd.axis] + w_term_s;
                    OP_DONE: begin
                        r_o_sat   <= r_sat || r_fsat || (r_field > FACC_W'(32'hFFFF_FFFF))
                                     || (|w_gover);
                        r_o_field <= (r_fsat || (r_field > FACC_W'(32'hFFFF_FFFF)))
                                     ? 32'hFFFF_FFFF : r_field[31:0];
                        r_o_gx    <= w_gout[0];
                        r_o_gy    <= w_gout[1];
                        r_o_gz    <= w_gout[2];
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.s_zero   = (r_s == '0);
    assign o_status.gclamp   = r_gclamp;

    assign o_field_value  = r_o_field;
    assign o_grad_x       = r_o_gx;
    assign o_grad_y       = r_o_gy;
    assign o_grad_z       = r_o_gz;
    assign o_saturated    = r_o_sat;
    assign o_result_valid = r_valid;

endmodule
`default_nettype wire

### hw/rtl/mfe_ctrl.sv
// mfe_ctrl: sequencer stepping a query through every active sphere entry.
// Depends on mfe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mfe_ctrl
    import mfe_pkg::*;
#(
    parameter int unsigned MAX_SPHERES = 256,
    parameter int unsigned AW = 8,
    parameter int unsigned CW = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic          i_req_type,
    input  wire logic [8:0]    i_sphere_count,
    input  wire t_dp_status    i_status,
    output t_dp_cmd            o_cmd,
    output logic [AW-1:0]      o_addr,
    output logic               o_busy
);

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_DIST, S_FDIV, S_FWAIT, S_FACC,
        S_MLO, S_MHI, S_GDIV, S_GWAIT, S_GACC, S_NEXT, S_DONE
    } t_state;

    t_state        r_state;
    logic [1:0]    r_axis;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] w_active;
    logic [31:0]   w_cnt;

    assign w_cnt    = 32'(i_sphere_count);
    assign w_active = CW'((w_cnt > MAX_SPHERES) ? MAX_SPHERES : w_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_axis  <= 2'd0;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx  <= '0;
                    r_axis <= 2'd0;
                    if (i_accept && (i_req_type == REQ_QUERY)) begin
                        r_state <= (w_active == '0) ? S_DONE : S_READ;
                    end
                end
                S_READ: r_state <= S_DIST;
                S_DIST: begin
                    r_axis <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    if (r_axis == 2'd2) r_state <= S_FDIV;
                end
                S_FDIV:  r_state <= i_status.s_zero ? S_NEXT : S_FWAIT;
                S_FWAIT: if (i_status.div_done) r_state <= S_FACC;
                S_FACC:  r_state <= S_MLO;
                S_MLO:   r_state <= S_MHI;
                S_MHI:   r_state <= S_GDIV;
                S_GDIV:  r_state <= S_GWAIT;
                S_GWAIT: if (i_status.gclamp || i_status.div_done) r_state <= S_GACC;
                S_GACC: begin
                    r_axis  <= (r_axis == 2'd2) ? 2'd0 : r_axis + 2'd1;
                    r_state <= (r_axis == 2'd2) ? S_NEXT : S_MLO;
                end
                S_NEXT: begin
                    r_idx   <= r_idx + CW'(1);
                    r_state <= (r_idx + CW'(1) == w_active) ? S_DONE : S_READ;
                end
                S_DONE:  r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.axis = r_axis;
        case (r_state)
            S_READ:  o_cmd.op = OP_READ;
            S_DIST:  o_cmd.op = OP_DIST;
            S_FDIV:  o_cmd.op = i_status.s_zero ? OP_ZERO : OP_FDIV;
            S_FACC:  o_cmd.op = OP_FACC;
            S_MLO:   o_cmd.op = OP_MLO;
            S_MHI:   o_cmd.op = OP_MHI;
            S_GDIV:  o_cmd.op = OP_GDIV;
            S_GACC:  o_cmd.op = OP_GACC;
            S_DONE:  o_cmd.op = OP_DONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    assign o_addr = r_idx[AW-1:0];
    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

### hw/rtl/metaball_field_evaluator_top.sv
// metaball_field_evaluator_top: inverse-square metaball field and gradient.
// Depends on mfe_pkg, mfe_ctrl, mfe_datapath (and mfe_div below it).
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  request  | start / busy           | i_req_type i_sphere_index i_coord_x/y/z
//           |                        | i_coord_is_nan
//  result   | o_result_valid strobe  | o_field_value o_grad_x/y/z o_saturated
//  config   | psel penable pwrite    | paddr pwdata / prdata, pready tied high
//
// A write stores the centre on accept and gives no result; NaN-flagged or
// out-of-range writes are dropped. A query walks entries 0..count-1, count
// capped at MAX_SPHERES; per entry: read, distance per axis, field divide,
// accumulate, then per axis two product steps, gradient divide, accumulate;
// then advance. Both divides share the single bit-serial divider. A centre
// hit skips the field divide and gradient steps; a clamped gradient term
// skips its divide. The one-cycle result strobe rises as busy falls and the
// receiver cannot stall it. Reset is synchronous; the centre table is kept.
`timescale 1ns / 1ps
`default_nettype none
module metaball_field_evaluator_top
    import mfe_pkg::*;
#(
    parameter int unsigned MAX_SPHERES = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request transaction
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_sphere_index,
    input  wire logic [31:0] i_coord_x,
    input  wire logic [31:0] i_coord_y,
    input  wire logic [31:0] i_coord_z,
    input  wire logic        i_coord_is_nan,
    // result transaction
    output logic             o_result_valid,
    output logic [31:0]      o_field_value,
    output logic [31:0]      o_grad_x,
    output logic [31:0]      o_grad_y,
    output logic [31:0]      o_grad_z,
    output logic             o_saturated,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int unsigned CW = $clog2(MAX_SPHERES + 1);

    logic [31:0] r_radius_sq;
    logic [8:0]  r_sph_count;
    logic        w_accept;
    logic        w_busy;
    t_dp_cmd     w_cmd;
    t_dp_status  w_status;
    logic [AW-1:0] w_addr;

    // register file; only paddr[2] selects the register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius_sq <= 32'h0001_0000;
            r_sph_count <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_RADIUS_SQ) r_radius_sq <= pwdata;
            else                           r_sph_count <= pwdata[8:0];
        end
    end
    assign prdata = (paddr[2] == REG_SPH_COUNT) ? 32'(r_sph_count) : r_radius_sq;

    assign w_accept = start && !w_busy;
    assign busy     = w_busy;

    mfe_ctrl #(
        .MAX_SPHERES (MAX_SPHERES),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_req_type     (i_req_type),
        .i_sphere_count (r_sph_count),
        .i_status       (w_status),
        .o_cmd          (w_cmd),
        .o_addr         (w_addr),
        .o_busy         (w_busy)
    );

    mfe_datapath #(
        .MAX_SPHERES (MAX_SPHERES),
        .AW          (AW)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_accept),
        .i_req_type       (i_req_type),
        .i_sphere_index   (i_sphere_index),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_coord_z        (i_coord_z),
        .i_coord_is_nan   (i_coord_is_nan),
        .i_radius_squared (r_radius_sq),
        .i_cmd            (w_cmd),
        .i_addr           (w_addr),
        .o_status         (w_status),
        .o_field_value    (o_field_value),
        .o_grad_x         (o_grad_x),
        .o_grad_y         (o_grad_y),
        .o_grad_z         (o_grad_z),
        .o_saturated      (o_saturated),
        .o_result_valid   (o_result_valid)
    );

endmodule
`default_nettype wire

### bench/tb.sv
// tb: self-checking bench for metaball_field_evaluator_top.
// Depends on mfe_pkg and the block's RTL only; holds its own field predictor.
`timescale 1ns / 1ps
module tb;
    import mfe_pkg::*;

    localparam int unsigned TABLE_DEPTH = 256;
    localparam logic [2:0]  ADDR_RADIUS = {REG_RADIUS_SQ, 2'b00};
    localparam logic [2:0]  ADDR_COUNT  = {REG_SPH_COUNT, 2'b00};
    localparam longint unsigned TERM_CLAMP = 64'd1 << 40;

    typedef struct {
        logic [31:0] field;
        logic [31:0] gx;
        logic [31:0] gy;
        logic [31:0] gz;
        logic        sat;
    } t_field_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_req_type;
    logic [7:0]  i_sphere_index;
    logic [31:0] i_coord_x;
    logic [31:0] i_coord_y;
    logic [31:0] i_coord_z;
    logic        i_coord_is_nan;
    logic        o_result_valid;
    logic [31:0] o_field_value;
    logic [31:0] o_grad_x;
    logic [31:0] o_grad_y;
    logic [31:0] o_grad_z;
    logic        o_saturated;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    metaball_field_evaluator_top DUT (.*);

    // shadow of the block: centre table and the two registers
    logic signed [31:0] centre_tab [TABLE_DEPTH][3];
    logic [31:0]        radius_sq;
    logic [8:0]         active_count;
    t_field_result      expected_fields [$];
    int                 idle_pct;
    bit                 failed;

    // 4 ns clock
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Predictor: exact integer field and gradient over the active entries.
    function automatic t_field_result eval_field(input logic signed [31:0] px,
                                                 input logic signed [31:0] py,
                                                 input logic signed [31:0] pz);
        t_field_result     r;
        logic signed [31:0] pt [3];
        longint signed     d [3];
        longint unsigned   mag [3];
        longint signed     gsum [3];
        longint unsigned   dist_sq;
        longint unsigned   term;
        longint unsigned   fsum;
        logic [127:0]      prod;
        logic [127:0]      quot;
        bit                sat;
        bit                fsat;
        int                n;
        pt[0] = px; pt[1] = py; pt[2] = pz;
        gsum = '{0, 0, 0};
        fsum = 0;
        sat = 0;
        fsat = 0;
        n = (active_count > TABLE_DEPTH) ? TABLE_DEPTH : active_count;
        for (int i = 0; i < n; i++) begin
            dist_sq = 0;
            for (int a = 0; a < 3; a++) begin
                d[a] = longint'(centre_tab[i][a]) - longint'(pt[a]);
                mag[a] = (d[a] < 0) ? longint'(-d[a]) : longint'(d[a]);
                dist_sq += (mag[a] * mag[a]) >> 16;
            end
            if (dist_sq == 0) begin
                // centre hit: field pinned, no gradient contribution
                sat = 1;
                fsat = 1;
                continue;
            end
            term = (longint'(radius_sq) << 16) / dist_sq;
            fsum += term;
            for (int a = 0; a < 3; a++) begin
                prod = 128'(2 * term) * 128'(mag[a]);
                quot = prod / 128'(dist_sq);
                if (quot > 128'(TERM_CLAMP)) begin
                    quot = 128'(TERM_CLAMP);
                    sat = 1;
                end
                gsum[a] += (d[a] < 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
            end
        end
        if (fsat || fsum > 64'hFFFF_FFFF) begin
            sat = 1;
            fsum = 64'hFFFF_FFFF;
        end
        r.field = fsum[31:0];
        for (int a = 0; a < 3; a++) begin
            if (gsum[a] > 64'sh7FFF_FFFF) begin
                gsum[a] = 64'sh7FFF_FFFF;
                sat = 1;
            end else if (gsum[a] < -64'sh8000_0000) begin
                gsum[a] = -64'sh8000_0000;
                sat = 1;
            end
        end
        r.gx = gsum[0][31:0];
        r.gy = gsum[1][31:0];
        r.gz = gsum[2][31:0];
        r.sat = sat;
        return r;
    endfunction

    // APB write: setup then access phase; pready is tied high
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_RADIUS) radius_sq = data;
        else active_count = data[8:0];
        @(negedge i_clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    // Drop start, wait for every expected result, then for the block to
    // fall quiet; a write gives no result, so pad a few cycles first.
    task automatic drain_block();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] r2, input logic [8:0] cnt);
        drain_block();
        reg_write(ADDR_RADIUS, r2);
        reg_write(ADDR_COUNT, {23'd0, cnt});
    endtask

    // Send one transaction; busy is read at the falling edge, so the value
    // seen there is the one the next rising edge acts on.
    task automatic send_item(input logic req, input logic [7:0] idx,
                             input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic nan);
        @(negedge i_clk);
        i_req_type = req; i_sphere_index = idx;
        i_coord_x = x; i_coord_y = y; i_coord_z = z; i_coord_is_nan = nan;
        start = 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        if (req == REQ_QUERY) begin
            expected_fields = {expected_fields, eval_field(x, y, z)};
        end else if (!nan) begin
            centre_tab[idx][0] = x;
            centre_tab[idx][1] = y;
            centre_tab[idx][2] = z;
        end
        if ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
            repeat ($urandom_range(4)) @(negedge i_clk);
        end
    endtask

    task automatic write_centre(input logic [7:0] idx, input logic [31:0] x,
                                input logic [31:0] y, input logic [31:0] z);
        send_item(REQ_WRITE, idx, x, y, z, 1'b0);
    endtask

    task automatic query_at(input logic [31:0] x, input logic [31:0] y,
                            input logic [31:0] z);
        send_item(REQ_QUERY, 8'($urandom), x, y, z, 1'(($urandom)));
    endtask

    // Result checker: one strobe per query, compared against the oldest guess
    always @(posedge i_clk) begin
        t_field_result e;
        if (i_rst_n && o_result_valid) begin
            if (expected_fields.size() == 0) begin
                $error("unexpected result transaction");
                failed = 1;
            end else begin
                e = expected_fields.pop_front();
                if (o_field_value !== e.field) begin
                    $error("field_value exp %h got %h", e.field, o_field_value);
                    failed = 1;
                end
                if (o_grad_x !== e.gx) begin
                    $error("grad_x exp %h got %h", e.gx, o_grad_x);
                    failed = 1;
                end
                if (o_grad_y !== e.gy) begin
                    $error("grad_y exp %h got %h", e.gy, o_grad_y);
                    failed = 1;
                end
                if (o_grad_z !== e.gz) begin
                    $error("grad_z exp %h got %h", e.gz, o_grad_z);
                    failed = 1;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, o_saturated);
                    failed = 1;
                end
            end
        end
    end

    // Edge cases: extreme coordinates, centre hits, clamped terms, empty sum,
    // skipped NaN writes and flags ignored on a query.
    task automatic test_directed();
        idle_pct = 0;
        write_centre(0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        write_centre(1, 32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
        write_centre(2, 32'h0000_0000, 32'h0000_0000, 32'h0000_0100);
        write_centre(3, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        for (int i = 4; i < 8; i++)
            write_centre(i, $urandom_range(32'h00FF_FFFF), $urandom, 32'(i << 16));
        // empty sum first: reset count is zero
        query_at(32'h1234_5678, 32'h8000_0000, 32'h7FFF_FFFF);
        set_regs(32'h0001_0000, 9'd4);
        query_at(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);  // farthest point
        query_at(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);  // on entry 1
        query_at(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // 256 raw off entry 2
        // NaN write must leave entry 1 untouched
        send_item(REQ_WRITE, 8'd1, 32'h0, 32'h0, 32'h0, 1'b1);
        query_at(32'h0001_8000, 32'h0002_0000, 32'hFFFF_0000);
        set_regs(32'hFFFF_FFFF, 9'd4);
        query_at(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);  // term clamp
        query_at(32'h0000_8000, 32'h0001_8000, 32'hFFFF_8000);  // field overflow
        set_regs(32'h0000_0000, 9'd8);
        query_at(32'h0001_0000, 32'h0002_0000, 32'hFFFF_0000);
        query_at($urandom, $urandom, $urandom);
    endtask

    // Random mix per sender idle setting; most queries land on or near stored centres
    task automatic test_random(input int pct, input int n_items);
        logic [31:0] c [3];
        int          k;
        logic [31:0] r2;
        idle_pct = pct;
        case ($urandom_range(3))
            0: r2 = 32'hFFFF_FFFF;
            1: r2 = 32'h0000_0000;
            default: r2 = $urandom_range(32'h0010_0000);
        endcase
        set_regs(r2, 9'($urandom_range(8)));
        for (int n = 0; n < n_items; n++) begin
            k = $urandom_range(7);
            case ($urandom_range(9))
                0, 1: write_centre(8'(k), $urandom_range(32'h0200_0000) - 32'h0100_0000,
                                   $urandom_range(32'h0200_0000) - 32'h0100_0000,
                                   $urandom_range(32'h0200_0000) - 32'h0100_0000);
                2: begin
                    // stray writes: skipped by NaN, or to entries beyond the sum
                    if ($urandom_range(1))
                        send_item(REQ_WRITE, 8'($urandom), $urandom, $urandom, $urandom, 1'b1);
                    else
                        write_centre(8'($urandom_range(255, 8)), $urandom, $urandom, $urandom);
                end
                3: query_at($urandom, $urandom, $urandom);
                4: query_at(centre_tab[k][0], centre_tab[k][1], centre_tab[k][2]);
                default: begin
                    for (int a = 0; a < 3; a++)
                        c[a] = centre_tab[k][a] + $urandom_range(32'h0008_0000)
                               - 32'h0004_0000;
                    query_at(c[0], c[1], c[2]);
                end
            endcase
        end
    endtask

    // Whole table in use, and a count beyond the table depth
    task automatic test_full_table();
        idle_pct = 10;
        for (int i = 0; i < TABLE_DEPTH; i++)
            write_centre(8'(i), $urandom, $urandom, $urandom_range(32'h00FF_FFFF));
        set_regs(32'hFFFF_FFFF, 9'd256);
        query_at(32'h0, 32'h0, 32'h0);
        query_at(centre_tab[255][0], centre_tab[255][1], centre_tab[255][2]);
        set_regs(32'h0004_0000, 9'd511);
        query_at($urandom, $urandom, $urandom);
    endtask

    initial begin
        failed = 0;
        idle_pct = 0;
        radius_sq = 32'h0001_0000;
        active_count = 9'd0;
        start = 0; i_req_type = 0; i_sphere_index = 0;
        i_coord_x = 0; i_coord_y = 0; i_coord_z = 0; i_coord_is_nan = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(0, 70);
        test_random(46, 70);
        test_random(0, 70);
        test_random(26, 70);
        test_full_table();

        @(negedge i_clk);
        start = 1'b0;
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (!failed) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog: several times the slowest legal run
    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
hw/rtl/mfe_pkg.sv
hw/rtl/mfe_div.sv
hw/rtl/mfe_datapath.sv
hw/rtl/mfe_ctrl.sv
hw/rtl/metaball_field_evaluator_top.sv
bench/tb.sv
